>>> hdl/brlmc_pkg.sv
// Shared types, constants and helpers for the button RGB LED mode controller.
package brlmc_pkg;

  typedef enum logic [1:0] {
    CMD_SECOND_DOWN = 2'd0,
    CMD_SECOND_UP   = 2'd1,
    CMD_FIRST_UP    = 2'd2,
    CMD_FADE_TICK   = 2'd3
  } cmd_t;

  localparam logic [2:0] MODE_RED   = 3'd0;
  localparam logic [2:0] MODE_BLUE  = 3'd1;
  localparam logic [2:0] MODE_GREEN = 3'd2;
  localparam logic [2:0] MODE_FADE  = 3'd4;
  localparam logic [2:0] MODE_MOTOR = 3'd5;

  localparam logic [7:0] LEVEL_MIN       = 8'd1;
  localparam logic [7:0] LEVEL_MAX       = 8'd254;
  localparam logic [7:0] LEVEL_STEP      = 8'd10;
  localparam logic [7:0] LEVEL_LOW_EDGE  = 8'd11;
  localparam logic [7:0] LEVEL_HIGH_EDGE = 8'd243;
  localparam logic [7:0] LEVEL_RESET_RED = 8'd255;

  localparam logic [2:0] SPEED_MIN      = 3'd1;
  localparam logic [2:0] SPEED_MAX      = 3'd5;
  localparam logic [2:0] SPEED_LOW_EDGE = 3'd2;

  localparam logic [5:0] MOTOR_MIN      = 6'd9;
  localparam logic [5:0] MOTOR_MAX      = 6'd44;
  localparam logic [5:0] MOTOR_LOW_EDGE = 6'd10;
  localparam logic [5:0] MOTOR_RESET    = 6'd10;

  localparam logic [2:0] COUNT_MAX   = 3'd6;
  localparam logic [1:0] PHASE_RESET = 2'd1;
  localparam logic [1:0] PHASE_LAST  = 2'd2;

  localparam logic [15:0] PERIOD_RESET = 16'd11362;

  // Division by 255: remainder thresholds for the quotient correction
  localparam logic [9:0] DIV255_ONE = 10'd255;
  localparam logic [9:0] DIV255_TWO = 10'd510;

  // Division by 45 (after a shift by 3 for 360): floor(2^24 / 45)
  localparam logic [18:0] DIV45_RECIP = 19'd372827;
  localparam logic [19:0] DIV45_ONE   = 20'd45;

  typedef struct packed {
    logic [2:0][7:0] levels;
    logic [2:0]      speed;
    logic [2:0]      mode;
    logic [5:0]      motor_step;
    logic [1:0]      fade_phase;
  } state_t;

  typedef struct packed {
    logic p;
    logic q;
    logic o;
  } load_t;

  function automatic logic [1:0] phase_up(input logic [1:0] ph);
    logic [1:0] r;
    case (ph)
      2'd0:    r = 2'd1;
      2'd1:    r = 2'd2;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] phase_down(input logic [1:0] ph);
    logic [1:0] r;
    case (ph)
      2'd0:    r = 2'd2;
      2'd1:    r = 2'd0;
      default: r = 2'd1;
    endcase
    return r;
  endfunction

endpackage

>>> hdl/brlmc_ctrl.sv
// Button and fade-tick state machine: levels, mode, speed, motor step.
module brlmc_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic [1:0]            command,
  input  logic                  second_held,
  output brlmc_pkg::state_t     st
);

  logic [2:0]        press_count;
  logic [2:0]        press_count_next;
  logic              fading_down;
  logic              fading_down_next;
  brlmc_pkg::state_t st_next;
  logic [1:0]        fade_idx;

  function automatic brlmc_pkg::state_t adjust_down(input brlmc_pkg::state_t s);
    brlmc_pkg::state_t r;
    logic [7:0]        lv;
    r  = s;
    lv = s.levels[s.mode[1:0]];
    if (s.mode <= brlmc_pkg::MODE_GREEN) begin
      r.levels[s.mode[1:0]] = (lv < brlmc_pkg::LEVEL_LOW_EDGE) ?
                              brlmc_pkg::LEVEL_MIN : lv - brlmc_pkg::LEVEL_STEP;
    end else if (s.mode == brlmc_pkg::MODE_FADE) begin
      r.speed = (s.speed < brlmc_pkg::SPEED_MAX) ? s.speed + 3'd1 : brlmc_pkg::SPEED_MAX;
    end else if (s.mode == brlmc_pkg::MODE_MOTOR) begin
      r.motor_step = (s.motor_step <= brlmc_pkg::MOTOR_LOW_EDGE) ?
                     brlmc_pkg::MOTOR_MIN : s.motor_step - 6'd1;
    end
    return r;
  endfunction

  function automatic brlmc_pkg::state_t adjust_up(input brlmc_pkg::state_t s);
    brlmc_pkg::state_t r;
    logic [7:0]        lv;
    r  = s;
    lv = s.levels[s.mode[1:0]];
    if (s.mode <= brlmc_pkg::MODE_GREEN) begin
      r.levels[s.mode[1:0]] = (lv >= brlmc_pkg::LEVEL_HIGH_EDGE) ?
                              brlmc_pkg::LEVEL_MAX : lv + brlmc_pkg::LEVEL_STEP;
    end else if (s.mode == brlmc_pkg::MODE_FADE) begin
      r.speed = (s.speed <= brlmc_pkg::SPEED_LOW_EDGE) ?
                brlmc_pkg::SPEED_MIN : s.speed - 3'd1;
    end else if (s.mode == brlmc_pkg::MODE_MOTOR) begin
      r.motor_step = (s.motor_step >= brlmc_pkg::MOTOR_MAX) ?
                     brlmc_pkg::MOTOR_MAX : s.motor_step + 6'd1;
    end
    return r;
  endfunction

  always_comb begin
    st_next          = st;
    press_count_next = press_count;
    fading_down_next = fading_down;
    fade_idx         = fading_down ? brlmc_pkg::phase_down(st.fade_phase) :
                                     brlmc_pkg::phase_up(st.fade_phase);
    if (accept) begin
      case (brlmc_pkg::cmd_t'(command))
        brlmc_pkg::CMD_SECOND_DOWN: begin
          press_count_next = '0;
        end
        brlmc_pkg::CMD_SECOND_UP: begin
          case (press_count)
            3'd1:    st_next.mode = brlmc_pkg::MODE_RED;
            3'd2:    st_next.mode = brlmc_pkg::MODE_BLUE;
            3'd3:    st_next.mode = brlmc_pkg::MODE_GREEN;
            3'd4:    st_next.mode = brlmc_pkg::MODE_FADE;
            3'd5:    st_next.mode = brlmc_pkg::MODE_MOTOR;
            default: st_next = adjust_down(st);
          endcase
        end
        brlmc_pkg::CMD_FIRST_UP: begin
          if (second_held) begin
            if (press_count < brlmc_pkg::COUNT_MAX) begin
              press_count_next = press_count + 3'd1;
            end
          end else begin
            st_next = adjust_up(st);
          end
        end
        brlmc_pkg::CMD_FADE_TICK: begin
          if (st.mode == brlmc_pkg::MODE_FADE) begin
            if (!fading_down) begin
              if (st.levels[fade_idx] >= brlmc_pkg::LEVEL_MAX) begin
                st_next.levels[fade_idx] = brlmc_pkg::LEVEL_MAX;
                st_next.fade_phase       = fade_idx;
                fading_down_next         = 1'b1;
              end else begin
                st_next.levels[fade_idx] = st.levels[fade_idx] + 8'd1;
              end
            end else begin
              if (st.levels[fade_idx] <= brlmc_pkg::LEVEL_MIN) begin
                st_next.levels[fade_idx] = brlmc_pkg::LEVEL_MIN;
                fading_down_next         = 1'b0;
              end else begin
                st_next.levels[fade_idx] = st.levels[fade_idx] - 8'd1;
              end
            end
          end
        end
        default: begin
          st_next = st;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.levels[0]  <= brlmc_pkg::LEVEL_RESET_RED;
      st.levels[1]  <= brlmc_pkg::LEVEL_MIN;
      st.levels[2]  <= brlmc_pkg::LEVEL_MIN;
      st.speed      <= brlmc_pkg::SPEED_MIN;
      st.mode       <= brlmc_pkg::MODE_FADE;
      st.motor_step <= brlmc_pkg::MOTOR_RESET;
      st.fade_phase <= brlmc_pkg::PHASE_RESET;
      press_count   <= '0;
      fading_down   <= 1'b0;
    end else begin
      st          <= st_next;
      press_count <= press_count_next;
      fading_down <= fading_down_next;
    end
  end

endmodule

>>> hdl/brlmc_level_duty.sv
// Channel duty pipeline: level times period, divided by 255.
module brlmc_level_duty (
  input  logic               clk,
  input  brlmc_pkg::load_t   load,
  input  logic [7:0]         level,
  input  logic [15:0]        period,
  output logic [15:0]        duty
);

  logic [23:0] prod;
  logic [24:0] sum;
  logic [15:0] q0_c;
  logic [25:0] r_full;
  logic [15:0] q0;
  logic [9:0]  rem;

  always_comb begin
    sum    = {1'b0, prod} + 25'(prod >> 8) + 25'(prod >> 16);
    q0_c   = sum[23:8];
    r_full = {2'd0, prod} - ({2'd0, q0_c, 8'd0} - {10'd0, q0_c});
  end

  always_ff @(posedge clk) begin
    if (load.p) begin
      prod <= 24'(level) * 24'(period);
    end
    if (load.q) begin
      q0  <= q0_c;
      rem <= r_full[9:0];
    end
    if (load.o) begin
      duty <= q0 + ((rem >= brlmc_pkg::DIV255_TWO) ? 16'd2 :
                    (rem >= brlmc_pkg::DIV255_ONE) ? 16'd1 : 16'd0);
    end
  end

endmodule

>>> hdl/brlmc_motor_duty.sv
// Motor duty pipeline: step times period, divided by 360.
module brlmc_motor_duty (
  input  logic               clk,
  input  brlmc_pkg::load_t   load,
  input  logic [5:0]         motor_step,
  input  logic [15:0]        period,
  output logic [15:0]        duty
);

  logic [21:0] prod;
  logic [18:0] y;
  logic [37:0] m;
  logic [13:0] q0;
  logic [19:0] q45;
  logic [19:0] rem;

  always_comb begin
    q0  = m[37:24];
    q45 = (20'(q0) << 5) + (20'(q0) << 3) + (20'(q0) << 2) + 20'(q0);
    rem = {1'b0, y} - q45;
  end

  always_ff @(posedge clk) begin
    if (load.p) begin
      prod <= 22'(motor_step) * 22'(period);
    end
    if (load.q) begin
      y <= prod[21:3];
      m <= 38'(prod[21:3]) * 38'(brlmc_pkg::DIV45_RECIP);
    end
    if (load.o) begin
      duty <= 16'(q0) + ((rem >= brlmc_pkg::DIV45_ONE) ? 16'd1 : 16'd0);
    end
  end

endmodule

>>> hdl/button_rgb_led_mode_controller_top.sv
// Top level of the button RGB LED mode controller.
// Takes one transaction per clock while s_tready is high and returns one result
// per transaction, in order. The state updates on the accepting edge, then three
// duty scaling stages follow (product, quotient estimate, remainder correction)
// and the result is offered from the last of them. Each stage holds its item while
// the next one is full, so up to four results can be in flight while m_tready
// is low. cfg_ready is always high; period_count takes effect on the next
// transaction and is meant to be written while no transaction is in flight.
module button_rgb_led_mode_controller_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // command[1:0], second_held[2], zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // duty_red, duty_blue, duty_green, duty_motor,
                                 // speed_factor, current_mode, zero pad
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  logic [15:0]       period_count;
  brlmc_pkg::state_t st;
  brlmc_pkg::load_t  load;
  logic              accept;
  logic              v1, v2, v3;
  logic              rdy1, rdy2, rdy3, rdy_o;
  logic [2:0]        speed_p, speed_q, speed_o;
  logic [2:0]        mode_p, mode_q, mode_o;
  logic [15:0]       duty_red, duty_blue, duty_green, duty_motor;

  assign cfg_ready = 1'b1;

  always_comb begin
    rdy_o    = !m_tvalid || m_tready;
    rdy3     = !v3 || rdy_o;
    rdy2     = !v2 || rdy3;
    rdy1     = !v1 || rdy2;
    s_tready = rdy1;
    accept   = s_tvalid && rdy1;
    load.p   = v1 && rdy2;
    load.q   = v2 && rdy3;
    load.o   = v3 && rdy_o;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      period_count <= brlmc_pkg::PERIOD_RESET;
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        period_count <= cfg_data;
      end
      if (rdy1) begin
        v1 <= s_tvalid;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy3) begin
        v3 <= v2;
      end
      if (rdy_o) begin
        m_tvalid <= v3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load.p) begin
      speed_p <= st.speed;
      mode_p  <= st.mode;
    end
    if (load.q) begin
      speed_q <= speed_p;
      mode_q  <= mode_p;
    end
    if (load.o) begin
      speed_o <= speed_q;
      mode_o  <= mode_q;
    end
  end

  brlmc_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .command     (s_tdata[1:0]),
    .second_held (s_tdata[2]),
    .st          (st)
  );

  brlmc_level_duty u_duty_red (
    .clk    (clk),
    .load   (load),
    .level  (st.levels[0]),
    .period (period_count),
    .duty   (duty_red)
  );

  brlmc_level_duty u_duty_blue (
    .clk    (clk),
    .load   (load),
    .level  (st.levels[1]),
    .period (period_count),
    .duty   (duty_blue)
  );

  brlmc_level_duty u_duty_green (
    .clk    (clk),
    .load   (load),
    .level  (st.levels[2]),
    .period (period_count),
    .duty   (duty_green)
  );

  brlmc_motor_duty u_duty_motor (
    .clk        (clk),
    .load       (load),
    .motor_step (st.motor_step),
    .period     (period_count),
    .duty       (duty_motor)
  );

  assign m_tdata = {2'd0, mode_o, speed_o, duty_motor, duty_green, duty_blue, duty_red};

  a_accept_occupies: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> v1)
    else $error("accepted transaction did not enter the first stage");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    v1 && v2 && v3 && m_tvalid && !m_tready |-> !s_tready)
    else $error("input taken while the pipeline is full and stalled");

  a_state_range: assert property (@(posedge clk) disable iff (rst)
    st.speed >= brlmc_pkg::SPEED_MIN && st.speed <= brlmc_pkg::SPEED_MAX &&
    st.motor_step >= brlmc_pkg::MOTOR_MIN && st.motor_step <= brlmc_pkg::MOTOR_MAX &&
    st.fade_phase <= brlmc_pkg::PHASE_LAST)
    else $error("control state left its legal range");

  a_mode_reachable: assert property (@(posedge clk) disable iff (rst)
    st.mode <= brlmc_pkg::MODE_GREEN || st.mode == brlmc_pkg::MODE_FADE ||
    st.mode == brlmc_pkg::MODE_MOTOR)
    else $error("mode register holds an unreachable mode");

endmodule

>>> verif/button_rgb_led_mode_controller_top_tb.sv
// Self-checking testbench for the button RGB LED mode controller top level.
module button_rgb_led_mode_controller_top_tb;

  typedef struct packed {
    logic [15:0] red, blue, green, motor;
    logic [2:0]  speed, mode;
  } duty_set_t;

  typedef struct packed {
    brlmc_pkg::cmd_t cmd;
    logic            held;
    bit              typed;
    duty_set_t       res;
  } stim_row_t;

  localparam int LATENCY        = 3;
  localparam int SEGMENT_ITEMS  = 48;
  localparam int LEVEL_DIVISOR  = 255;
  localparam int MOTOR_DIVISOR  = 360;
  localparam int TIMEOUT        = 2000000;

  localparam duty_set_t RESET_DUTIES = '{red: 16'd11362, blue: 16'd44, green: 16'd44,
                                         motor: 16'd315, speed: brlmc_pkg::SPEED_MIN,
                                         mode: brlmc_pkg::MODE_FADE};
  localparam duty_set_t NO_DUTIES = '0;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;    // command[1:0], second_held[2], zero pad
  logic        m_tvalid;
  logic        m_tready = 1'b1;
  logic [71:0] m_tdata;         // duty_red, duty_blue, duty_green, duty_motor,
                                // speed_factor, current_mode, zero pad
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  logic [7:0]  lvl [3];
  logic [2:0]  press_cnt, mode_q, speed_q;
  logic [5:0]  motor_q;
  logic [1:0]  phase_q;
  logic        falling_q;
  logic [15:0] period_q;

  duty_set_t expected_duties[$];
  int        mismatch_count = 0;
  int        sent_items = 0;
  bit        no_idle = 1'b0;
  int        tx_gap_pct = 0;
  int        rx_stall_pct = 0;

  stim_row_t directed_rows [26] = '{
    '{brlmc_pkg::CMD_SECOND_DOWN, 1'b0, 1'b1, RESET_DUTIES},
    '{brlmc_pkg::CMD_FADE_TICK,   1'b1, 1'b0, NO_DUTIES},
    '{brlmc_pkg::CMD_FIRST_UP,    1'b0, 1'b0, NO_DUTIES},
    '{brlmc_pkg::CMD_SECOND_UP,   1'b1, 1'b0, NO_DUTIES},
    '{brlmc_pkg::CMD_SECOND_UP,   1'b0, 1'b0, NO_DUTIES},
    '{brlmc_pkg::CMD_SECOND_UP,   1'b0, 1'b0, NO_DUTIES},
    '{brlmc_pkg::CMD_SECOND_UP,   1'b0, 1'b0, NO_DUTIES},
    '{brlmc_pkg::CMD_SECOND_UP,   1'b0, 1'b0, NO_DUTIES},
    '{brlmc_pkg::CMD_FIRST_UP,    1'b1, 1'b0, NO_DUTIES},
    '{brlmc_pkg::CMD_FIRST_UP,    1'b1, 1'b0, NO_DUTIES},
    '{brlmc_pkg::CMD_FIRST_UP,    1'b1, 1'b0, NO_DUTIES},
    '{brlmc_pkg::CMD_FIRST_UP,    1'b1, 1'b0, NO_DUTIES},
    '{brlmc_pkg::CMD_FIRST_UP,    1'b1, 1'b0, NO_DUTIES},
    '{brlmc_pkg::CMD_SECOND_UP,   1'b0, 1'b0, NO_DUTIES},
    '{brlmc_pkg::CMD_FIRST_UP,    1'b1, 1'b0, NO_DUTIES},
    '{brlmc_pkg::CMD_FIRST_UP,    1'b1, 1'b0, NO_DUTIES},
    '{brlmc_pkg::CMD_SECOND_UP,   1'b0, 1'b0, NO_DUTIES},
    '{brlmc_pkg::CMD_SECOND_UP,   1'b1, 1'b0, NO_DUTIES},
    '{brlmc_pkg::CMD_SECOND_DOWN, 1'b0, 1'b0, NO_DUTIES},
    '{brlmc_pkg::CMD_FIRST_UP,    1'b1, 1'b0, NO_DUTIES},
    '{brlmc_pkg::CMD_SECOND_UP,   1'b0, 1'b0, NO_DUTIES},
    '{brlmc_pkg::CMD_FIRST_UP,    1'b0, 1'b0, NO_DUTIES},
    '{brlmc_pkg::CMD_FADE_TICK,   1'b0, 1'b0, NO_DUTIES},
    '{brlmc_pkg::CMD_SECOND_DOWN, 1'b1, 1'b0, NO_DUTIES},
    '{brlmc_pkg::CMD_SECOND_UP,   1'b0, 1'b0, NO_DUTIES},
    '{brlmc_pkg::CMD_FIRST_UP,    1'b0, 1'b0, NO_DUTIES}
  };

  button_rgb_led_mode_controller_top DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic duty_set_t step_controller(brlmc_pkg::cmd_t cmd, logic held);
    int unsigned idx;
    logic [8:0]  bumped;
    duty_set_t   d;
    case (cmd)
      brlmc_pkg::CMD_SECOND_DOWN: begin
        press_cnt = '0;
      end
      brlmc_pkg::CMD_SECOND_UP: begin
        case (press_cnt)
          3'd1: mode_q = brlmc_pkg::MODE_RED;
          3'd2: mode_q = brlmc_pkg::MODE_BLUE;
          3'd3: mode_q = brlmc_pkg::MODE_GREEN;
          3'd4: mode_q = brlmc_pkg::MODE_FADE;
          3'd5: mode_q = brlmc_pkg::MODE_MOTOR;
          default: begin
            if (mode_q <= brlmc_pkg::MODE_GREEN) begin
              lvl[mode_q] = (lvl[mode_q] < brlmc_pkg::LEVEL_LOW_EDGE) ?
                            brlmc_pkg::LEVEL_MIN : lvl[mode_q] - brlmc_pkg::LEVEL_STEP;
            end else if (mode_q == brlmc_pkg::MODE_FADE) begin
              speed_q = (speed_q < brlmc_pkg::SPEED_MAX) ? speed_q + 3'd1 :
                        brlmc_pkg::SPEED_MAX;
            end else if (mode_q == brlmc_pkg::MODE_MOTOR) begin
              motor_q = (motor_q <= brlmc_pkg::MOTOR_MIN + 6'd1) ? brlmc_pkg::MOTOR_MIN :
                        motor_q - 6'd1;
            end
          end
        endcase
      end
      brlmc_pkg::CMD_FIRST_UP: begin
        if (held) begin
          if (press_cnt < brlmc_pkg::COUNT_MAX) press_cnt = press_cnt + 3'd1;
        end else if (mode_q <= brlmc_pkg::MODE_GREEN) begin
          lvl[mode_q] = (lvl[mode_q] >= brlmc_pkg::LEVEL_HIGH_EDGE) ?
                        brlmc_pkg::LEVEL_MAX : lvl[mode_q] + brlmc_pkg::LEVEL_STEP;
        end else if (mode_q == brlmc_pkg::MODE_FADE) begin
          speed_q = (speed_q <= brlmc_pkg::SPEED_MIN + 3'd1) ? brlmc_pkg::SPEED_MIN :
                    speed_q - 3'd1;
        end else if (mode_q == brlmc_pkg::MODE_MOTOR) begin
          motor_q = (motor_q >= brlmc_pkg::MOTOR_MAX) ? brlmc_pkg::MOTOR_MAX :
                    motor_q + 6'd1;
        end
      end
      default: begin
        if (mode_q == brlmc_pkg::MODE_FADE) begin
          if (!falling_q) begin
            idx = (32'(phase_q) + 1) % 3;
            bumped = {1'b0, lvl[idx]} + 9'd1;
            if (bumped > 9'(brlmc_pkg::LEVEL_MAX)) begin
              lvl[idx] = brlmc_pkg::LEVEL_MAX;
              falling_q = 1'b1;
              phase_q = 2'((32'(phase_q) + 1) % 3);
            end else begin
              lvl[idx] = bumped[7:0];
            end
          end else begin
            idx = (32'(phase_q) + 2) % 3;
            if (lvl[idx] <= brlmc_pkg::LEVEL_MIN) begin
              lvl[idx] = brlmc_pkg::LEVEL_MIN;
              falling_q = 1'b0;
            end else begin
              lvl[idx] = lvl[idx] - 8'd1;
            end
          end
        end
      end
    endcase
    d.red   = 16'((32'(lvl[0]) * 32'(period_q)) / LEVEL_DIVISOR);
    d.blue  = 16'((32'(lvl[1]) * 32'(period_q)) / LEVEL_DIVISOR);
    d.green = 16'((32'(lvl[2]) * 32'(period_q)) / LEVEL_DIVISOR);
    d.motor = 16'((32'(motor_q) * 32'(period_q)) / MOTOR_DIVISOR);
    d.speed = speed_q;
    d.mode  = mode_q;
    return d;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    $display("mismatch on %s: got %0d, expected %0d", field, got, want);
    mismatch_count++;
  endtask

  task automatic send_command(brlmc_pkg::cmd_t cmd, logic held, bit typed = 1'b0,
                              duty_set_t typed_res = '0);
    duty_set_t d;
    @(negedge clk);
    if (!no_idle && $urandom_range(1, 100) <= tx_gap_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'd0, held, cmd};
    do @(posedge clk); while (!s_tready);
    d = step_controller(cmd, held);
    expected_duties.push_back(typed ? typed_res : d);
    sent_items++;
  endtask

  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_duties.size() != 0) @(posedge clk);
  endtask

  task automatic write_period(logic [15:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    period_q = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_sequence();
    int kind;
    kind = $urandom_range(0, 99);
    if (kind < 30) begin
      send_command(brlmc_pkg::CMD_SECOND_DOWN, 1'($urandom));
      repeat (($urandom_range(0, 4) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 5))
        send_command(brlmc_pkg::CMD_FIRST_UP, 1'b1);
      send_command(brlmc_pkg::CMD_SECOND_UP, 1'($urandom));
    end else if (kind < 55) begin
      repeat ($urandom_range(1, 40)) send_command(brlmc_pkg::CMD_FIRST_UP, 1'b0);
    end else if (kind < 75) begin
      send_command(brlmc_pkg::CMD_SECOND_DOWN, 1'($urandom));
      repeat ($urandom_range(1, 30)) send_command(brlmc_pkg::CMD_SECOND_UP, 1'($urandom));
    end else if (kind < 92) begin
      repeat ($urandom_range(1, 80)) send_command(brlmc_pkg::CMD_FADE_TICK, 1'($urandom));
    end else begin
      repeat ($urandom_range(1, 8))
        send_command(brlmc_pkg::cmd_t'($urandom_range(0, 3)), 1'($urandom));
    end
  endtask

  // hold ready low in random bursts
  initial begin
    forever begin
      @(negedge clk);
      if (!no_idle && $urandom_range(1, 100) <= rx_stall_pct) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 19) - 1) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    duty_set_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_duties.size() == 0) begin
        report_mismatch("result with nothing pending", 1, 0);
      end else begin
        want = expected_duties.pop_front();
        if (m_tdata[15:0] !== want.red) report_mismatch("duty_red", m_tdata[15:0], want.red);
        if (m_tdata[31:16] !== want.blue)
          report_mismatch("duty_blue", m_tdata[31:16], want.blue);
        if (m_tdata[47:32] !== want.green)
          report_mismatch("duty_green", m_tdata[47:32], want.green);
        if (m_tdata[63:48] !== want.motor)
          report_mismatch("duty_motor", m_tdata[63:48], want.motor);
        if (m_tdata[66:64] !== want.speed)
          report_mismatch("speed_factor", m_tdata[66:64], want.speed);
        if (m_tdata[69:67] !== want.mode)
          report_mismatch("current_mode", m_tdata[69:67], want.mode);
      end
    end
  end

  initial begin
    #TIMEOUT;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int          seg_start;
    logic [15:0] period_pick;
    lvl[0]    = brlmc_pkg::LEVEL_RESET_RED;
    lvl[1]    = brlmc_pkg::LEVEL_MIN;
    lvl[2]    = brlmc_pkg::LEVEL_MIN;
    press_cnt = '0;
    mode_q    = brlmc_pkg::MODE_FADE;
    speed_q   = brlmc_pkg::SPEED_MIN;
    motor_q   = brlmc_pkg::MOTOR_RESET;
    phase_q   = brlmc_pkg::PHASE_RESET;
    falling_q = 1'b0;
    period_q  = brlmc_pkg::PERIOD_RESET;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_command(directed_rows[i].cmd, directed_rows[i].held, directed_rows[i].typed,
                   directed_rows[i].res);

    for (int seg = 0; seg < 8; seg++) begin
      drain();
      case (seg)
        0:       period_pick = 16'hFFFF;
        1:       period_pick = 16'd1;
        2:       period_pick = 16'd0;
        4:       period_pick = 16'd255;
        6:       period_pick = 16'd360;
        7:       period_pick = brlmc_pkg::PERIOD_RESET;
        default: period_pick = 16'($urandom_range(1, 65535));
      endcase
      write_period(period_pick);
      no_idle      = (seg == 7);
      tx_gap_pct   = $urandom_range(0, 2) * 12;
      rx_stall_pct = $urandom_range(0, 2) * 8;
      seg_start    = sent_items;
      while (sent_items - seg_start < SEGMENT_ITEMS) run_sequence();
    end

    drain();
    repeat (LATENCY * 4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/brlmc_pkg.sv
hdl/brlmc_ctrl.sv
hdl/brlmc_level_duty.sv
hdl/brlmc_motor_duty.sv
hdl/button_rgb_led_mode_controller_top.sv
verif/button_rgb_led_mode_controller_top_tb.sv
